FILE: hdl/msp_pkg.sv
// Shared types, codes and defaults of the mirror session packet disposition block.
`default_nettype none

package msp_pkg;

    localparam int SESSION_COUNT_DEF = 32768;
    localparam int QUEUE_DEPTH_DEF   = 2;
    localparam logic [8:0] RECIRC_PORT_RESET = 9'd510;

    localparam logic [2:0] CMD_ADD      = 3'd0;
    localparam logic [2:0] CMD_DELETE   = 3'd1;
    localparam logic [2:0] CMD_QUERY    = 3'd2;
    localparam logic [2:0] CMD_INGRESS  = 3'd3;
    localparam logic [2:0] CMD_EGRESS   = 3'd4;

    typedef enum logic [3:0] {
        ACT_STATUS      = 4'd0,
        ACT_CLONE_GROUP = 4'd1,
        ACT_CLONE_PORT  = 4'd2,
        ACT_DROP        = 4'd3,
        ACT_RESUBMIT    = 4'd4,
        ACT_MULTICAST   = 4'd5,
        ACT_UNICAST     = 4'd6,
        ACT_RECIRCULATE = 4'd7,
        ACT_TRANSMIT    = 4'd8
    } t_action;

    typedef enum logic [2:0] {
        PATH_NONE        = 3'd0,
        PATH_UNICAST     = 3'd1,
        PATH_MULTICAST   = 3'd2,
        PATH_CLONE_I2E   = 3'd3,
        PATH_CLONE_E2E   = 3'd4,
        PATH_RESUBMIT    = 3'd5,
        PATH_RECIRCULATE = 3'd6
    } t_path;

    typedef enum logic [1:0] {
        OP_STATUS  = 2'd0,
        OP_QUERY   = 2'd1,
        OP_INGRESS = 2'd2,
        OP_EGRESS  = 2'd3
    } t_op;

    typedef struct packed {
        logic        conf;
        logic        group_valid;
        logic [15:0] group;
        logic        port_valid;
        logic [8:0]  port;
    } t_entry;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] session_id;
        logic        new_group_valid;
        logic [15:0] new_group;
        logic        new_port_valid;
        logic [8:0]  new_port;
        logic        clone_flag;
        logic        drop_flag;
        logic        resubmit_flag;
        logic [15:0] mcast_group;
        logic [8:0]  packet_port;
        logic [7:0]  service_class;
    } t_item;

    typedef struct packed {
        t_op         op;
        logic        success;
        logic        group_valid;
        logic [15:0] group;
        logic        port_valid;
        logic [8:0]  port;
        logic        clone_g;
        logic        clone_p;
        logic        drop;
        logic        resub;
        logic [15:0] mgrp;
        logic [8:0]  pport;
        logic [7:0]  cls;
    } t_job;

    typedef struct packed {
        t_action     action;
        logic        success;
        logic        group_valid;
        logic [15:0] group;
        logic        port_valid;
        logic [8:0]  port;
        t_path       path;
        logic [7:0]  class_out;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

FILE: hdl/msp_front.sv
// Front end: session table, clearing pass, lookup and classification of each beat.
`default_nettype none

module msp_front #(
    parameter int SESSION_COUNT = msp_pkg::SESSION_COUNT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire msp_pkg::t_item i_item,
    output logic               o_full,
    input  wire logic          i_q_full,
    output logic               o_job_push,
    output msp_pkg::t_job      o_job
);
    import msp_pkg::*;

    localparam int AW = $clog2(SESSION_COUNT);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } t_fstate;

    t_fstate       r_state, n_state;
    logic [AW-1:0] r_clr_addr;
    t_item         r_item;
    t_entry        r_rd_data;
    t_entry        r_mem [SESSION_COUNT];

    logic          accept;
    logic          id_ok;
    t_entry        e;
    logic          tbl_wr;
    t_entry        tbl_data;
    logic          wr_en;
    t_entry        wr_data;
    logic [AW-1:0] wr_addr;
    t_job          n_job;

    assign o_full     = (r_state != ST_IDLE);
    assign accept     = i_push && (r_state == ST_IDLE);
    assign id_ok      = ({1'b0, r_item.session_id} < 17'(SESSION_COUNT));
    assign e          = id_ok ? r_rd_data : '0;
    assign o_job_push = (r_state == ST_LOOK) && !i_q_full;
    assign o_job      = n_job;

    always_comb begin
        n_job        = '0;
        n_job.op     = OP_STATUS;
        tbl_wr       = 1'b0;
        tbl_data     = '0;
        case (r_item.command)
            CMD_ADD: begin
                tbl_wr               = id_ok;
                tbl_data.conf        = 1'b1;
                tbl_data.group_valid = r_item.new_group_valid;
                tbl_data.group       = r_item.new_group;
                tbl_data.port_valid  = r_item.new_port_valid;
                tbl_data.port        = r_item.new_port;
                n_job.success        = id_ok;
            end
            CMD_DELETE: begin
                tbl_wr        = id_ok && e.conf;
                n_job.success = id_ok && e.conf;
            end
            CMD_QUERY: begin
                n_job.op          = OP_QUERY;
                n_job.success     = e.conf;
                n_job.group_valid = e.conf && e.group_valid;
                n_job.group       = e.conf ? e.group : '0;
                n_job.port_valid  = e.conf && e.port_valid;
                n_job.port        = e.conf ? e.port : '0;
            end
            CMD_INGRESS, CMD_EGRESS: begin
                n_job.op      = (r_item.command == CMD_INGRESS) ? OP_INGRESS : OP_EGRESS;
                n_job.clone_g = r_item.clone_flag && e.conf && e.group_valid;
                n_job.clone_p = r_item.clone_flag && e.conf && e.port_valid;
                n_job.group   = e.group;
                n_job.port    = e.port;
                n_job.drop    = r_item.drop_flag;
                n_job.resub   = r_item.resubmit_flag;
                n_job.mgrp    = r_item.mcast_group;
                n_job.pport   = r_item.packet_port;
                n_job.cls     = r_item.service_class;
            end
            default: begin
                n_job.success = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = o_job_push && tbl_wr;
            wr_addr = r_item.session_id[AW-1:0];
            wr_data = tbl_data;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(SESSION_COUNT - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                if (!i_q_full) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item    <= i_item;
            r_rd_data <= r_mem[i_item.session_id[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
    end

endmodule

`default_nettype wire

FILE: hdl/msp_queue.sv
// Short job queue between the front end and the result sequencer.
`default_nettype none

module msp_queue #(
    parameter int DEPTH = msp_pkg::QUEUE_DEPTH_DEF,
    parameter int W     = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic [W-1:0]      o_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

`default_nettype wire

FILE: hdl/msp_back.sv
// Back end: recirculate port register and sequencing of clone copies and verdicts.
`default_nettype none

module msp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [8:0]    i_cfg_data,
    output logic               o_cfg_ready,
    input  wire logic          i_q_empty,
    input  wire msp_pkg::t_job i_job,
    output logic               o_q_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output msp_pkg::t_result   o_result
);
    import msp_pkg::*;

    logic [8:0] r_recirc_port;
    logic       r_done_g;
    logic       r_done_p;
    logic       r_out_valid;
    t_result    r_out;
    t_result    n_out;
    logic       cur_g;
    logic       cur_p;
    logic       load;
    t_path      clone_path;

    assign o_cfg_ready = 1'b1;
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;
    assign cur_g       = i_job.clone_g && !r_done_g;
    assign cur_p       = i_job.clone_p && !r_done_p && !cur_g;
    assign load        = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop     = load && !cur_g && !cur_p;
    assign clone_path  = (i_job.op == OP_INGRESS) ? PATH_CLONE_I2E : PATH_CLONE_E2E;

    always_comb begin
        n_out        = '0;
        n_out.action = ACT_STATUS;
        n_out.path   = PATH_NONE;
        if (cur_g) begin
            n_out.action = ACT_CLONE_GROUP;
            n_out.group  = i_job.group;
            n_out.path   = clone_path;
        end else if (cur_p) begin
            n_out.action = ACT_CLONE_PORT;
            n_out.port   = i_job.port;
            n_out.path   = clone_path;
        end else begin
            n_out.last = 1'b1;
            case (i_job.op)
                OP_STATUS: begin
                    n_out.success = i_job.success;
                end
                OP_QUERY: begin
                    n_out.success     = i_job.success;
                    n_out.group_valid = i_job.group_valid;
                    n_out.group       = i_job.group;
                    n_out.port_valid  = i_job.port_valid;
                    n_out.port        = i_job.port;
                end
                OP_INGRESS: begin
                    if (i_job.drop) begin
                        n_out.action = ACT_DROP;
                    end else if (i_job.resub) begin
                        n_out.action = ACT_RESUBMIT;
                        n_out.path   = PATH_RESUBMIT;
                    end else if (i_job.mgrp != '0) begin
                        n_out.action    = ACT_MULTICAST;
                        n_out.group     = i_job.mgrp;
                        n_out.path      = PATH_MULTICAST;
                        n_out.class_out = i_job.cls;
                    end else begin
                        n_out.action    = ACT_UNICAST;
                        n_out.port      = i_job.pport;
                        n_out.path      = PATH_UNICAST;
                        n_out.class_out = i_job.cls;
                    end
                end
                OP_EGRESS: begin
                    if (i_job.drop) begin
                        n_out.action = ACT_DROP;
                    end else if (i_job.pport == r_recirc_port) begin
                        n_out.action = ACT_RECIRCULATE;
                        n_out.port   = i_job.pport;
                        n_out.path   = PATH_RECIRCULATE;
                    end else begin
                        n_out.action    = ACT_TRANSMIT;
                        n_out.port      = i_job.pport;
                        n_out.class_out = i_job.cls;
                    end
                end
                default: begin
                    n_out.success = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recirc_port <= RECIRC_PORT_RESET;
            r_done_g      <= 1'b0;
            r_done_p      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) r_recirc_port <= i_cfg_data;
            if (load) begin
                r_out_valid <= 1'b1;
                if (cur_g) begin
                    r_done_g <= 1'b1;
                end else if (cur_p) begin
                    r_done_p <= 1'b1;
                end else begin
                    r_done_g <= 1'b0;
                    r_done_p <= 1'b0;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_done_needs_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done_g || r_done_p) |-> !i_q_empty)
        else $error("clone progress held without a queued job");
    a_done_p_clone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_p |-> i_job.clone_p)
        else $error("port clone marked done for a job without one");
    a_pop_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_out_valid && r_out.last))
        else $error("job retired without a final beat");
`endif

endmodule

`default_nettype wire

FILE: hdl/mirror_session_packet_disposition.sv
// Top level of the mirror session packet disposition block.
//
// channel   direction  handshake                     payload
// input     in         push / full                   command, session, flags, ports
// result    out        empty / pop                   action, status, group, port, path
// config    in         i_cfg_valid / o_cfg_ready     recirculate port (9 bits)
//
// The front end takes a new input beat only after the last is done: first the registered
// session table read, then classifies and writes back the table, waiting on a full queue.
// The back end emits 1 to 3 results per item, one per cycle while jobs wait and pop is high.
// After reset a clearing pass writes every table entry, with full high.
// Config writes are taken at any time; results stall only on pop.
`default_nettype none

module mirror_session_packet_disposition #(
    parameter int SESSION_COUNT = msp_pkg::SESSION_COUNT_DEF,
    parameter int QUEUE_DEPTH   = msp_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [2:0]  i_command,
    input  wire logic [15:0] i_session_id,
    input  wire logic        i_new_group_valid,
    input  wire logic [15:0] i_new_group,
    input  wire logic        i_new_port_valid,
    input  wire logic [8:0]  i_new_port,
    input  wire logic        i_clone_flag,
    input  wire logic        i_drop_flag,
    input  wire logic        i_resubmit_flag,
    input  wire logic [15:0] i_mcast_group,
    input  wire logic [8:0]  i_packet_port,
    input  wire logic [7:0]  i_service_class,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       o_action,
    output logic             o_success,
    output logic             o_group_valid,
    output logic [15:0]      o_group,
    output logic             o_port_valid,
    output logic [8:0]       o_port,
    output logic [2:0]       o_path,
    output logic [7:0]       o_class_out,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [8:0]  i_cfg_data
);
    import msp_pkg::*;

    t_item   item;
    t_job    front_job;
    t_job    q_job;
    logic    job_push;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    t_result result;

    assign item.command         = i_command;
    assign item.session_id      = i_session_id;
    assign item.new_group_valid = i_new_group_valid;
    assign item.new_group       = i_new_group;
    assign item.new_port_valid  = i_new_port_valid;
    assign item.new_port        = i_new_port;
    assign item.clone_flag      = i_clone_flag;
    assign item.drop_flag       = i_drop_flag;
    assign item.resubmit_flag   = i_resubmit_flag;
    assign item.mcast_group     = i_mcast_group;
    assign item.packet_port     = i_packet_port;
    assign item.service_class   = i_service_class;

    msp_front #(
        .SESSION_COUNT(SESSION_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_item     (item),
        .o_full     (full),
        .i_q_full   (q_full),
        .o_job_push (job_push),
        .o_job      (front_job)
    );

    msp_queue #(
        .DEPTH(QUEUE_DEPTH),
        .W    ($bits(t_job))
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_job)
    );

    msp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_q_empty   (q_empty),
        .i_job       (q_job),
        .o_q_pop     (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (result)
    );

    assign o_action      = result.action;
    assign o_success     = result.success;
    assign o_group_valid = result.group_valid;
    assign o_group       = result.group;
    assign o_port_valid  = result.port_valid;
    assign o_port        = result.port;
    assign o_path        = result.path;
    assign o_class_out   = result.class_out;
    assign o_last        = result.last;

endmodule

`default_nettype wire

FILE: sim/mirror_session_packet_disposition_tb.sv
// Testbench for the mirror session packet disposition block.
`timescale 1ns / 1ps

module mirror_session_packet_disposition_tb;

    import msp_pkg::*;

    localparam int SESSION_NUM    = SESSION_COUNT_DEF;
    localparam int MAX_SESSION_ID = (1 << 15) - 1;
    localparam int SETTLE_CYCLES  = 16;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        push              = 1'b0;
    logic        full;
    logic [2:0]  i_command         = '0;
    logic [15:0] i_session_id      = '0;
    logic        i_new_group_valid = 1'b0;
    logic [15:0] i_new_group       = '0;
    logic        i_new_port_valid  = 1'b0;
    logic [8:0]  i_new_port        = '0;
    logic        i_clone_flag      = 1'b0;
    logic        i_drop_flag       = 1'b0;
    logic        i_resubmit_flag   = 1'b0;
    logic [15:0] i_mcast_group     = '0;
    logic [8:0]  i_packet_port     = '0;
    logic [7:0]  i_service_class   = '0;
    logic        empty;
    logic        pop               = 1'b0;
    logic [3:0]  o_action;
    logic        o_success;
    logic        o_group_valid;
    logic [15:0] o_group;
    logic        o_port_valid;
    logic [8:0]  o_port;
    logic [2:0]  o_path;
    logic [7:0]  o_class_out;
    logic        o_last;
    logic        i_cfg_valid       = 1'b0;
    logic        o_cfg_ready;
    logic [8:0]  i_cfg_data        = '0;

    t_entry      sessions [SESSION_NUM];
    logic [8:0]  recirc_port;
    t_result     pending_results [$];
    int          mismatch_count = 0;
    int unsigned tx_idle_max    = 3;
    int unsigned rx_idle_max    = 3;

    mirror_session_packet_disposition dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_command         (i_command),
        .i_session_id      (i_session_id),
        .i_new_group_valid (i_new_group_valid),
        .i_new_group       (i_new_group),
        .i_new_port_valid  (i_new_port_valid),
        .i_new_port        (i_new_port),
        .i_clone_flag      (i_clone_flag),
        .i_drop_flag       (i_drop_flag),
        .i_resubmit_flag   (i_resubmit_flag),
        .i_mcast_group     (i_mcast_group),
        .i_packet_port     (i_packet_port),
        .i_service_class   (i_service_class),
        .empty             (empty),
        .pop               (pop),
        .o_action          (o_action),
        .o_success         (o_success),
        .o_group_valid     (o_group_valid),
        .o_group           (o_group),
        .o_port_valid      (o_port_valid),
        .o_port            (o_port),
        .o_path            (o_path),
        .o_class_out       (o_class_out),
        .o_last            (o_last),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void predict_outcome(t_item it);
        t_result res [$];
        t_result r;
        t_entry  e;
        t_path   cpath;
        logic    id_ok;
        int      idx;
        idx   = int'(it.session_id);
        id_ok = (idx <= MAX_SESSION_ID) && (idx < SESSION_NUM);
        e     = id_ok ? sessions[idx] : '0;
        r     = '0;
        case (it.command)
            CMD_ADD: begin
                if (id_ok) begin
                    e             = '0;
                    e.conf        = 1'b1;
                    e.group_valid = it.new_group_valid;
                    e.group       = it.new_group;
                    e.port_valid  = it.new_port_valid;
                    e.port        = it.new_port;
                    sessions[idx] = e;
                    r.success     = 1'b1;
                end
                res = {res, r};
            end
            CMD_DELETE: begin
                if (id_ok && e.conf) begin
                    sessions[idx] = '0;
                    r.success     = 1'b1;
                end
                res = {res, r};
            end
            CMD_QUERY: begin
                if (e.conf) begin
                    r.success     = 1'b1;
                    r.group_valid = e.group_valid;
                    r.group       = e.group;
                    r.port_valid  = e.port_valid;
                    r.port        = e.port;
                end
                res = {res, r};
            end
            CMD_INGRESS, CMD_EGRESS: begin
                cpath = (it.command == CMD_INGRESS) ? PATH_CLONE_I2E : PATH_CLONE_E2E;
                if (it.clone_flag && e.conf) begin
                    if (e.group_valid) begin
                        r        = '0;
                        r.action = ACT_CLONE_GROUP;
                        r.group  = e.group;
                        r.path   = cpath;
                        res      = {res, r};
                    end
                    if (e.port_valid) begin
                        r        = '0;
                        r.action = ACT_CLONE_PORT;
                        r.port   = e.port;
                        r.path   = cpath;
                        res      = {res, r};
                    end
                end
                r = '0;
                if (it.drop_flag) begin
                    r.action = ACT_DROP;
                end else if (it.command == CMD_INGRESS) begin
                    if (it.resubmit_flag) begin
                        r.action = ACT_RESUBMIT;
                        r.path   = PATH_RESUBMIT;
                    end else if (it.mcast_group != 16'd0) begin
                        r.action    = ACT_MULTICAST;
                        r.group     = it.mcast_group;
                        r.path      = PATH_MULTICAST;
                        r.class_out = it.service_class;
                    end else begin
                        r.action    = ACT_UNICAST;
                        r.port      = it.packet_port;
                        r.path      = PATH_UNICAST;
                        r.class_out = it.service_class;
                    end
                end else if (it.packet_port == recirc_port) begin
                    r.action = ACT_RECIRCULATE;
                    r.port   = it.packet_port;
                    r.path   = PATH_RECIRCULATE;
                end else begin
                    r.action    = ACT_TRANSMIT;
                    r.port      = it.packet_port;
                    r.class_out = it.service_class;
                end
                res = {res, r};
            end
            default: res = {res, r};
        endcase
        foreach (res[i]) begin
            r               = res[i];
            r.last          = (i == res.size() - 1);
            pending_results = {pending_results, r};
        end
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t  %s mismatch: expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic t_item make_item(logic [2:0] cmd, logic [15:0] id);
        t_item it;
        it            = '0;
        it.command    = cmd;
        it.session_id = id;
        return it;
    endfunction

    task automatic send_item(input t_item it);
        int unsigned gap;
        gap = $urandom_range(tx_idle_max, 0);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_command         <= it.command;
        i_session_id      <= it.session_id;
        i_new_group_valid <= it.new_group_valid;
        i_new_group       <= it.new_group;
        i_new_port_valid  <= it.new_port_valid;
        i_new_port        <= it.new_port;
        i_clone_flag      <= it.clone_flag;
        i_drop_flag       <= it.drop_flag;
        i_resubmit_flag   <= it.resubmit_flag;
        i_mcast_group     <= it.mcast_group;
        i_packet_port     <= it.packet_port;
        i_service_class   <= it.service_class;
        push              <= 1'b1;
        do @(posedge i_clk); while (full);
        predict_outcome(it);
    endtask

    task automatic wait_for_idle();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_recirc_port(input logic [8:0] value);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        recirc_port  = value;
    endtask

    // Result side: stall at random, then take and check one beat.
    initial begin : result_monitor
        int unsigned stall;
        t_result     want;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = $urandom_range(rx_idle_max, 0);
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (pending_results.size() == 0) begin
                $display("%0t  unexpected result: expected none actual action %0h last %0b",
                         $time, o_action, o_last);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("action", 32'(want.action), 32'(o_action));
                check_field("success", 32'(want.success), 32'(o_success));
                check_field("group_valid", 32'(want.group_valid), 32'(o_group_valid));
                check_field("group", 32'(want.group), 32'(o_group));
                check_field("port_valid", 32'(want.port_valid), 32'(o_port_valid));
                check_field("port", 32'(want.port), 32'(o_port));
                check_field("path", 32'(want.path), 32'(o_path));
                check_field("class_out", 32'(want.class_out), 32'(o_class_out));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    task automatic test_recirculate_default();
        t_item it;
        it               = make_item(CMD_EGRESS, 16'd0);
        it.clone_flag    = 1'b1;
        it.packet_port   = RECIRC_PORT_RESET;
        it.service_class = 8'h5A;
        send_item(it);
    endtask

    task automatic test_session_commands();
        t_item it;
        it                 = make_item(CMD_ADD, 16'd0);
        it.new_group_valid = 1'b1;
        it.new_group       = 16'h0000;
        it.new_port_valid  = 1'b1;
        it.new_port        = 9'h1FF;
        send_item(it);
        it                 = make_item(CMD_ADD, 16'(MAX_SESSION_ID));
        it.new_group_valid = 1'b1;
        it.new_group       = 16'hFFFF;
        it.new_port        = 9'h0AA;
        send_item(it);
        it                 = make_item(CMD_ADD, 16'h8000);
        it.new_group_valid = 1'b1;
        it.new_port_valid  = 1'b1;
        send_item(it);
        it                 = make_item(CMD_ADD, 16'hFFFF);
        it.new_port_valid  = 1'b1;
        send_item(it);
        it                 = make_item(CMD_ADD, 16'd5);
        it.new_group       = 16'h1234;
        it.new_port        = 9'h155;
        send_item(it);
        send_item(make_item(CMD_QUERY, 16'd0));
        send_item(make_item(CMD_QUERY, 16'(MAX_SESSION_ID)));
        send_item(make_item(CMD_QUERY, 16'hFFFF));
        send_item(make_item(CMD_DELETE, 16'h9C40));
    endtask

    task automatic test_ingress_disposition();
        t_item it;
        it                 = make_item(CMD_INGRESS, 16'd0);
        it.clone_flag      = 1'b1;
        it.packet_port     = 9'h1FF;
        it.service_class   = 8'hFF;
        send_item(it);
        it                 = make_item(CMD_INGRESS, 16'(MAX_SESSION_ID));
        it.clone_flag      = 1'b1;
        it.resubmit_flag   = 1'b1;
        it.mcast_group     = 16'h0001;
        it.service_class   = 8'h11;
        send_item(it);
        it                 = make_item(CMD_INGRESS, 16'd0);
        it.clone_flag      = 1'b1;
        it.drop_flag       = 1'b1;
        it.resubmit_flag   = 1'b1;
        send_item(it);
        it                 = make_item(CMD_INGRESS, 16'd0);
        it.mcast_group     = 16'hFFFF;
        it.packet_port     = 9'h0F0;
        it.service_class   = 8'hAA;
        send_item(it);
        it                 = make_item(CMD_INGRESS, 16'd5);
        it.clone_flag      = 1'b1;
        it.packet_port     = 9'h100;
        it.service_class   = 8'h80;
        send_item(it);
    endtask

    task automatic test_egress_disposition();
        t_item it;
        it                 = make_item(CMD_ADD, 16'd0);
        it.new_group       = 16'hBEEF;
        it.new_port_valid  = 1'b1;
        it.new_port        = 9'd3;
        send_item(it);
        it                 = make_item(CMD_EGRESS, 16'd0);
        it.clone_flag      = 1'b1;
        it.resubmit_flag   = 1'b1;
        it.mcast_group     = 16'd7;
        it.packet_port     = 9'd3;
        it.service_class   = 8'h3C;
        send_item(it);
        send_item(make_item(CMD_DELETE, 16'd0));
        send_item(make_item(CMD_DELETE, 16'd0));
        send_item(make_item(CMD_QUERY, 16'd0));
    endtask

    task automatic test_unknown_commands();
        t_item it;
        for (int c = CMD_EGRESS + 1; c < (1 << $bits(i_command)); c++) begin
            it                 = make_item(3'(c), 16'd5);
            it.clone_flag      = 1'b1;
            it.new_port_valid  = 1'b1;
            it.service_class   = 8'hC3;
            send_item(it);
        end
    endtask

    task automatic test_recirculate_config();
        t_item it;
        wait_for_idle();
        write_recirc_port(9'd0);
        it                 = make_item(CMD_EGRESS, 16'd1);
        it.service_class   = 8'h01;
        send_item(it);
        it.packet_port     = RECIRC_PORT_RESET;
        send_item(it);
        wait_for_idle();
        write_recirc_port(9'h1FF);
        it.packet_port     = 9'h1FF;
        send_item(it);
        it.drop_flag       = 1'b1;
        send_item(it);
    endtask

    function automatic t_item random_item();
        t_item       it;
        int unsigned sel;
        it  = '0;
        sel = $urandom_range(99, 0);
        if (sel < 15)      it.command = CMD_ADD;
        else if (sel < 25) it.command = CMD_DELETE;
        else if (sel < 37) it.command = CMD_QUERY;
        else if (sel < 65) it.command = CMD_INGRESS;
        else if (sel < 95) it.command = CMD_EGRESS;
        else               it.command = CMD_EGRESS + 3'($urandom_range(3, 1));
        case ($urandom_range(9, 0))
            0:       it.session_id = 16'($urandom);
            1:       it.session_id = 16'h8000 | 16'($urandom);
            default: it.session_id = ($urandom_range(1, 0) ? 16'(MAX_SESSION_ID - 7) : 16'd0)
                                     + 16'($urandom_range(7, 0));
        endcase
        it.new_group_valid = 1'($urandom);
        it.new_group       = 16'($urandom);
        it.new_port_valid  = 1'($urandom);
        it.new_port        = 9'($urandom);
        it.clone_flag      = $urandom_range(9, 0) < 7;
        it.drop_flag       = $urandom_range(3, 0) == 0;
        it.resubmit_flag   = $urandom_range(3, 0) == 0;
        it.mcast_group     = $urandom_range(1, 0) ? 16'd0 : 16'($urandom);
        it.packet_port     = ($urandom_range(2, 0) == 0) ? recirc_port : 9'($urandom);
        it.service_class   = 8'($urandom);
        return it;
    endfunction

    task automatic run_random_phase(input logic [8:0] port, input int unsigned tx_max,
                                    input int unsigned rx_max, input int count);
        wait_for_idle();
        write_recirc_port(port);
        tx_idle_max = tx_max;
        rx_idle_max = rx_max;
        repeat (count) send_item(random_item());
    endtask

    task automatic test_random_traffic();
        run_random_phase(9'($urandom), 7, 7, 50);
        run_random_phase(9'd0, 0, 0, 50);
        run_random_phase(9'h1FF, 0, 7, 50);
        run_random_phase(9'($urandom), 7, 0, 50);
    endtask

    initial begin
        foreach (sessions[i]) sessions[i] = '0;
        recirc_port = RECIRC_PORT_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_recirculate_default();
        test_session_commands();
        test_ingress_disposition();
        test_egress_disposition();
        test_unknown_commands();
        test_recirculate_config();
        test_random_traffic();
        wait_for_idle();
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #400_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/msp_pkg.sv
hdl/msp_front.sv
hdl/msp_queue.sv
hdl/msp_back.sv
hdl/mirror_session_packet_disposition.sv
sim/mirror_session_packet_disposition_tb.sv
